// ===== hw/rtl/s2e_pkg.sv =====
// Shared constants, types and sizes for the 2x2 symmetric eigendecomposition block.
`default_nettype none
package s2e_pkg;

  // vector component format and width
  localparam int VEC_FRAC_BITS = 14;
  localparam int VEC_W         = 16;
  localparam int VEC_ONE       = 2 ** VEC_FRAC_BITS;

  // integer square root: one root bit per stage
  localparam int SQ_STEPS = 35;
  localparam int SQ_RAD_W = 2 * SQ_STEPS;
  localparam int SQ_REM_W = SQ_STEPS + 2;

  // unnormalized eigenvector components and their magnitudes
  localparam int COMP_W = 36;
  localparam int MAG_W  = 35;
  localparam int LO_W   = 18;
  localparam int HI_W   = MAG_W - LO_W;

  // normalizing divider: integer bit, fraction bits and a rounding bit
  localparam int DIV_STEPS = VEC_FRAC_BITS + 1;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // back pipeline: three setup stages, root, five vector stages, root, divider
  localparam int BACK_LAT = 3 + SQ_STEPS + 5 + SQ_STEPS + DIV_LAT;

  // classified matrix: difference, doubled off-diagonal and trace
  typedef struct packed {
    logic signed [32:0] d;
    logic signed [33:0] e;
    logic signed [32:0] tr;
  } mat_t;

  typedef struct packed {
    logic [31:0] eig_major;
    logic [31:0] eig_minor;
    logic        sat;
    logic        degen1;
    logic        degen2;
  } eig_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x1;
    logic signed [COMP_W-1:0] y1;
    logic signed [COMP_W-1:0] x2;
    logic signed [COMP_W-1:0] y2;
    eig_t                     eig;
  } vec_sb_t;

  // queue read side as seen by the back
  typedef struct packed {
    logic valid;
    mat_t item;
  } q_rd_t;

  typedef struct packed {
    eig_t             eig;
    logic [VEC_W-1:0] vec1_x;
    logic [VEC_W-1:0] vec1_y;
    logic [VEC_W-1:0] vec2_x;
    logic [VEC_W-1:0] vec2_y;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/s2e_queue.sv =====
// Short FIFO between the front classifier and the back pipeline.
`default_nettype none
module s2e_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire s2e_pkg::mat_t wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output s2e_pkg::q_rd_t     rd
);

  s2e_pkg::mat_t                mem [0:s2e_pkg::Q_DEPTH-1];
  logic [s2e_pkg::Q_AW-1:0]     wr_ptr;
  logic [s2e_pkg::Q_AW-1:0]     rd_ptr;
  logic [s2e_pkg::Q_AW:0]       count;
  logic                         do_wr;
  logic                         do_rd;

  assign full  = (count == (s2e_pkg::Q_AW+1)'(s2e_pkg::Q_DEPTH));
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && (count != '0);

  assign rd.valid = (count != '0);
  assign rd.item  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/s2e_front.sv =====
// Front classifier: forms difference, doubled off-diagonal and trace of a matrix.
`default_nettype none
module s2e_front (
  input  wire logic signed [31:0] diag_first,
  input  wire logic signed [31:0] diag_second,
  input  wire logic signed [31:0] off_diag,
  output s2e_pkg::mat_t           item
);

  always_comb begin
    item.d  = 33'(diag_first) - 33'(diag_second);
    item.e  = {off_diag[31], off_diag, 1'b0};
    item.tr = 33'(diag_first) + 33'(diag_second);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/s2e_isqrt.sv =====
// Pipelined integer square root, one root bit resolved per stage.
`default_nettype none
module s2e_isqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [s2e_pkg::SQ_RAD_W-1:0]  rad_in,
  output logic      [s2e_pkg::SQ_STEPS-1:0]  root_out
);

  logic [s2e_pkg::SQ_RAD_W-1:0] rad  [0:s2e_pkg::SQ_STEPS];
  logic [s2e_pkg::SQ_STEPS-1:0] root [0:s2e_pkg::SQ_STEPS];
  logic [s2e_pkg::SQ_REM_W-1:0] rem  [0:s2e_pkg::SQ_STEPS];

  assign rad[0]  = rad_in;
  assign root[0] = '0;
  assign rem[0]  = '0;

  for (genvar k = 1; k <= s2e_pkg::SQ_STEPS; k++) begin : g_step
    logic [s2e_pkg::SQ_REM_W+1:0] cand;
    logic [s2e_pkg::SQ_REM_W+1:0] trial;

    // bring down two radicand bits, try root*4+1
    always_comb begin
      cand  = {rem[k-1], rad[k-1][s2e_pkg::SQ_RAD_W-1 -: 2]};
      trial = {2'b00, root[k-1], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k] <= rad[k-1] << 2;
        if (cand >= trial) begin
          rem[k]  <= s2e_pkg::SQ_REM_W'(cand - trial);
          root[k] <= {root[k-1][s2e_pkg::SQ_STEPS-2:0], 1'b1};
        end else begin
          rem[k]  <= s2e_pkg::SQ_REM_W'(cand);
          root[k] <= {root[k-1][s2e_pkg::SQ_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  assign root_out = root[s2e_pkg::SQ_STEPS];

endmodule
`default_nettype wire

// ===== hw/rtl/s2e_div.sv =====
// Pipelined normalizing divider: rounded |num| * 2^frac / den with the sign of num.
`default_nettype none
module s2e_div (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [s2e_pkg::COMP_W-1:0]   num,
  input  wire logic        [s2e_pkg::SQ_STEPS-1:0] den,
  output logic             [s2e_pkg::VEC_W-1:0]    comp_out
);

  localparam int RW = s2e_pkg::SQ_STEPS;
  localparam int QW = s2e_pkg::DIV_STEPS + 1;

  logic [RW-1:0] r    [0:s2e_pkg::DIV_STEPS];
  logic [QW-1:0] q    [0:s2e_pkg::DIV_STEPS];
  logic [RW-1:0] dv   [0:s2e_pkg::DIV_STEPS];
  logic          neg  [0:s2e_pkg::DIV_STEPS];
  logic          zero [0:s2e_pkg::DIV_STEPS];

  logic [s2e_pkg::MAG_W-1:0] mag;
  logic [RW-1:0]             mag_ext;
  logic [QW:0]               q_round;
  logic [s2e_pkg::VEC_W-1:0] q_mag;

  // integer bit of the quotient
  always_comb begin
    mag     = s2e_pkg::MAG_W'(num < 0 ? -num : num);
    mag_ext = RW'(mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (mag_ext >= den) begin
        r[0] <= mag_ext - den;
        q[0] <= QW'(1);
      end else begin
        r[0] <= mag_ext;
        q[0] <= '0;
      end
      dv[0]   <= den;
      neg[0]  <= (num < 0);
      zero[0] <= (den == '0);
    end
  end

  // one fraction bit per stage
  for (genvar k = 1; k <= s2e_pkg::DIV_STEPS; k++) begin : g_step
    logic [RW:0] r2;
    assign r2 = {r[k-1], 1'b0};

    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= {1'b0, dv[k-1]}) begin
          r[k] <= RW'(r2 - {1'b0, dv[k-1]});
          q[k] <= {q[k-1][QW-2:0], 1'b1};
        end else begin
          r[k] <= RW'(r2);
          q[k] <= {q[k-1][QW-2:0], 1'b0};
        end
        dv[k]   <= dv[k-1];
        neg[k]  <= neg[k-1];
        zero[k] <= zero[k-1];
      end
    end
  end

  // round half up, apply sign, zero for an empty vector
  always_comb begin
    q_round = ({1'b0, q[s2e_pkg::DIV_STEPS]} + (QW+1)'(1)) >> 1;
    q_mag   = s2e_pkg::VEC_W'(q_round);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero[s2e_pkg::DIV_STEPS]) begin
        comp_out <= '0;
      end else if (neg[s2e_pkg::DIV_STEPS]) begin
        comp_out <= -q_mag;
      end else begin
        comp_out <= q_mag;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/s2e_back.sv =====
// Back pipeline: eigenvalue root, eigenvector formation, norm roots and normalization.
`default_nettype none
module s2e_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire s2e_pkg::q_rd_t q_rd,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                out_valid,
  output s2e_pkg::res_t       res
);

  localparam int SQ = s2e_pkg::SQ_STEPS;
  localparam int CW = s2e_pkg::COMP_W;
  localparam int MW = s2e_pkg::MAG_W;
  localparam int HW = s2e_pkg::HI_W;
  localparam int LW = s2e_pkg::LO_W;
  localparam int RW = s2e_pkg::SQ_RAD_W;

  logic                         en;
  logic [s2e_pkg::BACK_LAT-1:0] v;

  // global advance: move whenever the last stage is free or being taken
  assign en        = !v[s2e_pkg::BACK_LAT-1] || pop;
  assign q_pop     = en && q_rd.valid;
  assign out_valid = v[s2e_pkg::BACK_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[s2e_pkg::BACK_LAT-2:0], q_rd.valid};
    end
  end

  // ---- setup: magnitudes, squares, radicand d^2 + e^2
  s2e_pkg::mat_t  m0, m1, m2;
  logic [31:0]    dm, cm;
  logic [63:0]    dd, cc;
  logic [RW-1:0]  s_eig;

  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= q_rd.item;
      dm <= 32'(q_rd.item.d < 0 ? -q_rd.item.d : q_rd.item.d);
      cm <= 32'((q_rd.item.e < 0 ? -q_rd.item.e : q_rd.item.e) >>> 1);
      m1 <= m0;
      dd <= 64'(dm) * 64'(dm);
      cc <= 64'(cm) * 64'(cm);
      m2 <= m1;
      s_eig <= RW'(dd) + (RW'(cc) << 2);
    end
  end

  // ---- root of the discriminant
  logic [SQ-1:0]  b_root;
  s2e_pkg::mat_t  sb1 [1:SQ];

  s2e_isqrt u_sqrt_eig (
    .clk      (clk),
    .en       (en),
    .rad_in   (s_eig),
    .root_out (b_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb1[1] <= m2;
    end
  end
  for (genvar k = 2; k <= SQ; k++) begin : g_sb1
    always_ff @(posedge clk) begin
      if (en) begin
        sb1[k] <= sb1[k-1];
      end
    end
  end

  // ---- eigenvalues and doubled eigenvectors
  logic signed [CW-1:0] dx, ex, bx, tx;
  logic signed [CW-1:0] sum_hi, sum_lo, half_hi, half_lo;
  logic signed [CW-1:0] x1n, y1n, x2n, y2n;
  logic                 sat_hi_p, sat_hi_n, sat_lo_p, sat_lo_n;
  s2e_pkg::vec_sb_t     p3, p4, p5, p6, p7;

  always_comb begin
    dx      = CW'(sb1[SQ].d);
    ex      = CW'(sb1[SQ].e);
    tx      = CW'(sb1[SQ].tr);
    bx      = $signed({1'b0, b_root});
    sum_hi  = tx + bx;
    sum_lo  = tx - bx;
    half_hi = sum_hi >>> 1;
    half_lo = sum_lo >>> 1;
    sat_hi_p = half_hi > CW'(64'sh7FFF_FFFF);
    sat_hi_n = half_hi < -CW'(64'sh8000_0000);
    sat_lo_p = half_lo > CW'(64'sh7FFF_FFFF);
    sat_lo_n = half_lo < -CW'(64'sh8000_0000);
    x1n = ex - dx - bx;
    y1n = bx - dx - ex;
    x2n = ex - dx + bx;
    y2n = -dx - ex - bx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3.x1 <= x1n;
      p3.y1 <= y1n;
      p3.x2 <= x2n;
      p3.y2 <= y2n;
      p3.eig.eig_major <= sat_hi_p ? 32'h7FFF_FFFF :
                          sat_hi_n ? 32'h8000_0000 : 32'(half_hi);
      p3.eig.eig_minor <= sat_lo_p ? 32'h7FFF_FFFF :
                          sat_lo_n ? 32'h8000_0000 : 32'(half_lo);
      p3.eig.sat    <= sat_hi_p || sat_hi_n || sat_lo_p || sat_lo_n;
      p3.eig.degen1 <= (x1n == '0) && (y1n == '0);
      p3.eig.degen2 <= (x2n == '0) && (y2n == '0);
    end
  end

  // ---- squared norms through 18-bit partial products
  logic [MW-1:0]    mg [0:3];
  logic [2*HW-1:0]  pp_hh [0:3];
  logic [HW+LW-1:0] pp_hl [0:3];
  logic [2*LW-1:0]  pp_ll [0:3];
  logic [RW-1:0]    sq [0:3];
  logic [RW-1:0]    s_v1, s_v2;
  logic signed [CW-1:0] comp3 [0:3];

  assign comp3[0] = p3.x1;
  assign comp3[1] = p3.y1;
  assign comp3[2] = p3.x2;
  assign comp3[3] = p3.y2;

  for (genvar i = 0; i < 4; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        mg[i]    <= MW'(comp3[i] < 0 ? -comp3[i] : comp3[i]);
        pp_hh[i] <= (2*HW)'(mg[i][MW-1:LW]) * (2*HW)'(mg[i][MW-1:LW]);
        pp_hl[i] <= (HW+LW)'(mg[i][MW-1:LW]) * (HW+LW)'(mg[i][LW-1:0]);
        pp_ll[i] <= (2*LW)'(mg[i][LW-1:0]) * (2*LW)'(mg[i][LW-1:0]);
        sq[i]    <= (RW'(pp_hh[i]) << (2*LW)) + (RW'(pp_hl[i]) << (LW+1)) + RW'(pp_ll[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4   <= p3;
      p5   <= p4;
      p6   <= p5;
      p7   <= p6;
      s_v1 <= sq[0] + sq[1];
      s_v2 <= sq[2] + sq[3];
    end
  end

  // ---- vector norms
  logic [SQ-1:0]    n1, n2;
  s2e_pkg::vec_sb_t sb2 [1:SQ];

  s2e_isqrt u_sqrt_v1 (
    .clk      (clk),
    .en       (en),
    .rad_in   (s_v1),
    .root_out (n1)
  );

  s2e_isqrt u_sqrt_v2 (
    .clk      (clk),
    .en       (en),
    .rad_in   (s_v2),
    .root_out (n2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb2[1] <= p7;
    end
  end
  for (genvar k = 2; k <= SQ; k++) begin : g_sb2
    always_ff @(posedge clk) begin
      if (en) begin
        sb2[k] <= sb2[k-1];
      end
    end
  end

  // ---- normalization
  s2e_pkg::eig_t sb3 [1:s2e_pkg::DIV_LAT];

  s2e_div u_div_x1 (.clk(clk), .en(en), .num(sb2[SQ].x1), .den(n1), .comp_out(res.vec1_x));
  s2e_div u_div_y1 (.clk(clk), .en(en), .num(sb2[SQ].y1), .den(n1), .comp_out(res.vec1_y));
  s2e_div u_div_x2 (.clk(clk), .en(en), .num(sb2[SQ].x2), .den(n2), .comp_out(res.vec2_x));
  s2e_div u_div_y2 (.clk(clk), .en(en), .num(sb2[SQ].y2), .den(n2), .comp_out(res.vec2_y));

  always_ff @(posedge clk) begin
    if (en) begin
      sb3[1] <= sb2[SQ].eig;
    end
  end
  for (genvar k = 2; k <= s2e_pkg::DIV_LAT; k++) begin : g_sb3
    always_ff @(posedge clk) begin
      if (en) begin
        sb3[k] <= sb3[k-1];
      end
    end
  end

  assign res.eig = sb3[s2e_pkg::DIV_LAT];

endmodule
`default_nettype wire

// ===== hw/rtl/sym2x2_eigen_decompose.sv =====
// Top level: eigenvalues and unit eigenvectors of a symmetric 2x2 matrix.
// Throughput: one matrix per cycle; the back pipeline advances as one unit and stalls
// only while the oldest result waits for pop.
// A 4-entry queue separates push from the back pipeline, so full rises only under back-pressure.
// Reset (synchronous, rst high) empties the queue and clears all pipeline valid bits.
`default_nettype none
module sym2x2_eigen_decompose (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic signed [31:0]  diag_first,
  input  wire logic signed [31:0]  diag_second,
  input  wire logic signed [31:0]  off_diag,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [31:0]       eig_major,
  output logic signed [31:0]       eig_minor,
  output logic signed [15:0]       vec1_x,
  output logic signed [15:0]       vec1_y,
  output logic signed [15:0]       vec2_x,
  output logic signed [15:0]       vec2_y,
  output logic                     vec1_degenerate,
  output logic                     vec2_degenerate,
  output logic                     eig_saturated
);

  s2e_pkg::mat_t  item;
  s2e_pkg::q_rd_t q_rd;
  s2e_pkg::res_t  res;
  logic           q_pop;
  logic           out_valid;

  s2e_front u_front (
    .diag_first  (diag_first),
    .diag_second (diag_second),
    .off_diag    (off_diag),
    .item        (item)
  );

  s2e_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (item),
    .full    (full),
    .rd_en   (q_pop),
    .rd      (q_rd)
  );

  s2e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .res       (res)
  );

  // result ports
  assign empty           = !out_valid;
  assign eig_major       = $signed(res.eig.eig_major);
  assign eig_minor       = $signed(res.eig.eig_minor);
  assign vec1_x          = $signed(res.vec1_x);
  assign vec1_y          = $signed(res.vec1_y);
  assign vec2_x          = $signed(res.vec2_x);
  assign vec2_y          = $signed(res.vec2_y);
  assign vec1_degenerate = res.eig.degen1;
  assign vec2_degenerate = res.eig.degen2;
  assign eig_saturated   = res.eig.sat;

  // ---- assertions
  a_eig_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> eig_major >= eig_minor)
    else $error("major eigenvalue below minor eigenvalue");

  a_degen1_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && vec1_degenerate) |-> (vec1_x == 16'sd0 && vec1_y == 16'sd0))
    else $error("degenerate first vector not zero");

  a_degen2_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && vec2_degenerate) |-> (vec2_x == 16'sd0 && vec2_y == 16'sd0))
    else $error("degenerate second vector not zero");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (vec1_x <= s2e_pkg::VEC_ONE && vec1_x >= -s2e_pkg::VEC_ONE &&
                vec2_y <= s2e_pkg::VEC_ONE && vec2_y >= -s2e_pkg::VEC_ONE))
    else $error("eigenvector component beyond unit length");

endmodule
`default_nettype wire
